// ===== hw/rtl/bounded_array_table_engine_defines.svh =====
`ifndef BOUNDED_ARRAY_TABLE_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_TABLE_ENGINE_DEFINES_SVH

// Require cons in the same cycle as ante, outside reset.
`define BATE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Require cons in the cycle after ante, outside reset.
`define BATE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bate_pkg.sv =====
package bate_pkg;

   // Action codes of an input transfer
   typedef enum logic [3:0] {
      ACT_PUSH    = 4'd0,
      ACT_POP     = 4'd1,
      ACT_GET     = 4'd2,
      ACT_SET     = 4'd3,
      ACT_REM_VAL = 4'd4,
      ACT_REM_IDX = 4'd5,
      ACT_FIND    = 4'd6,
      ACT_CLEAR   = 4'd7,
      ACT_REVERSE = 4'd8
   } bate_action_type;

   // Status codes of a result transfer
   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_RANGE    = 3'd1,
      STS_UNDER    = 3'd2,
      STS_NOTFOUND = 3'd3,
      STS_FULL     = 3'd4,
      STS_NULL     = 3'd5
   } bate_status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RD_WAIT,
      S_SCAN,
      S_DROP,
      S_MOVE,
      S_SHIFT,
      S_REV_RDH,
      S_REV_WRL,
      S_REV_WRH,
      S_DONE
   } bate_state_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [7:0]  index;
      logic [31:0] value;
   } bate_req_type;

   typedef struct packed {
      bate_status_type status;
      logic [31:0]     read_value;
      logic [7:0]      found_index;
      logic [8:0]      fill_count;
   } bate_rsp_type;

endpackage

// ===== hw/rtl/bounded_array_table_engine.sv =====
// Channel  | Ports                                | Transfer when
// ---------+--------------------------------------+------------------------------
// request  | req_valid, req_stall, req_data       | req_valid && !req_stall
// response | rsp_valid, rsp_stall, rsp_data       | rsp_valid && !rsp_stall
// config   | csr_wr_en, csr_wr_data               | csr_wr_en
//
// One request at a time: req_stall is high from acceptance until the sequencer is idle
// again. Find reads one entry per cycle and stops at the first match; removal by value
// or by index closes the gap by moving the last entry in or by shifting later entries down.
// Reset empties the array and clears removal mode; a stalled result waits in the output
// register while the next request runs, and the sequencer holds a further one behind it.

module bounded_array_table_engine #(
   parameter int CAPACITY = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bate_pkg::bate_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bate_pkg::bate_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);

   import bate_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                   removal_mode_ff, removal_mode_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bate_rsp_type           rsp_data_ff, rsp_data_in;

   logic                   idle;
   logic                   start;
   logic                   res_valid;
   logic                   res_take;
   bate_rsp_type           res_data;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic                   mem_re;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_rdata;

   // Accept a request only while the sequencer is free
   assign req_stall = !idle;
   assign start     = req_valid && !req_stall;
   assign res_take  = res_valid && (!rsp_valid_ff || !rsp_stall);

   // Removal mode register
   always_comb begin
      removal_mode_in = removal_mode_ff;
      if (csr_wr_en) begin
         removal_mode_in = csr_wr_data;
      end
   end

   // Output register: load on take, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         removal_mode_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         removal_mode_ff <= removal_mode_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bate_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .removal_mode (removal_mode_ff),
      .idle         (idle),
      .res_valid    (res_valid),
      .res_take     (res_take),
      .res_data     (res_data),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   bate_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

// ===== hw/rtl/bate_ram.sv =====
module bate_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read one word, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bate_ctrl.sv =====
`include "bounded_array_table_engine_defines.svh"

module bate_ctrl #(
   parameter int CAPACITY = 256,
   parameter int VALUE_WIDTH = 32,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bate_pkg::bate_req_type req_data,
   input  logic                   removal_mode,
   output logic                   idle,
   output logic                   res_valid,
   input  logic                   res_take,
   output bate_pkg::bate_rsp_type res_data,
   output logic                   mem_we,
   output logic [AW-1:0]          mem_waddr,
   output logic [VALUE_WIDTH-1:0] mem_wdata,
   output logic                   mem_re,
   output logic [AW-1:0]          mem_raddr,
   input  logic [VALUE_WIDTH-1:0] mem_rdata
);

   import bate_pkg::*;

   localparam int XW = (CW > 8) ? CW : 8;

   bate_state_type         state_ff, state_in;
   bate_action_type        action_ff, action_in;
   logic [7:0]             idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_a_ff, ptr_a_in;
   logic [CW-1:0]          ptr_b_ff, ptr_b_in;
   logic                   flag_ff, flag_in;
   logic [VALUE_WIDTH-1:0] hold_ff, hold_in;
   bate_status_type        status_ff, status_in;
   logic [VALUE_WIDTH-1:0] rd_ff, rd_in;
   logic [7:0]             fi_ff, fi_in;

   logic [63:0]   val_ext;
   logic [63:0]   rd_ext;
   logic [XW-1:0] idx_x;
   logic [CW-1:0] last;
   logic          idx_ok;
   logic          hit;
   logic          rev_more;

   // Shared comparator and bounds
   assign val_ext  = 64'(req_data.value);
   assign rd_ext   = 64'(rd_ff);
   assign idx_x    = XW'(idx_ff);
   assign last     = count_ff - CW'(1);
   assign idx_ok   = idx_x < XW'(count_ff);
   assign hit      = (mem_rdata == val_ff);
   assign rev_more = (ptr_a_ff + CW'(2)) < ptr_b_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      ptr_a_ff  <= ptr_a_in;
      ptr_b_ff  <= ptr_b_in;
      flag_ff   <= flag_in;
      hold_ff   <= hold_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
      fi_ff     <= fi_in;
   end

   // Sequence one action over the memory port
   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      ptr_a_in  = ptr_a_ff;
      ptr_b_in  = ptr_b_ff;
      flag_in   = flag_ff;
      hold_in   = hold_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      fi_in     = fi_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in = bate_action_type'(req_data.action);
               idx_in    = req_data.index;
               val_in    = val_ext[VALUE_WIDTH-1:0];
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = STS_OK;
            rd_in     = '0;
            fi_in     = '0;
            state_in  = S_DONE;
            unique case (action_ff)
               ACT_PUSH: begin
                  if (val_ff == '0) begin
                     status_in = STS_NULL;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     status_in = STS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[AW-1:0];
                     mem_wdata = val_ff;
                     count_in  = count_ff + CW'(1);
                  end
               end
               ACT_POP: begin
                  if (count_ff == '0) begin
                     status_in = STS_UNDER;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = last[AW-1:0];
                     count_in  = last;
                     state_in  = S_RD_WAIT;
                  end
               end
               ACT_GET: begin
                  if (idx_ok) begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_x[AW-1:0];
                     state_in  = S_RD_WAIT;
                  end else begin
                     status_in = STS_RANGE;
                  end
               end
               ACT_SET: begin
                  if (val_ff == '0) begin
                     status_in = STS_NULL;
                  end else if (idx_ok) begin
                     mem_we    = 1'b1;
                     mem_waddr = idx_x[AW-1:0];
                     mem_wdata = val_ff;
                  end else begin
                     status_in = STS_RANGE;
                  end
               end
               ACT_REM_VAL: begin
                  if (val_ff == '0) begin
                     status_in = STS_NULL;
                  end else begin
                     ptr_a_in = '0;
                     flag_in  = 1'b0;
                     state_in = S_SCAN;
                  end
               end
               ACT_REM_IDX: begin
                  if (idx_ok) begin
                     ptr_b_in = idx_x[CW-1:0];
                     state_in = S_DROP;
                  end else begin
                     status_in = STS_RANGE;
                  end
               end
               ACT_FIND: begin
                  ptr_a_in = '0;
                  flag_in  = 1'b0;
                  state_in = S_SCAN;
               end
               ACT_CLEAR: begin
                  count_in = '0;
               end
               ACT_REVERSE: begin
                  if (count_ff > CW'(1)) begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     ptr_a_in  = '0;
                     ptr_b_in  = last;
                     state_in  = S_REV_RDH;
                  end
               end
               default: begin
               end
            endcase
         end

         // Capture the word for get and pop
         S_RD_WAIT: begin
            rd_in    = mem_rdata;
            state_in = S_DONE;
         end

         // Issue one read and compare the previous one per cycle
         S_SCAN: begin
            if (flag_ff && hit) begin
               flag_in = 1'b0;
               if (action_ff == ACT_FIND) begin
                  fi_in    = 8'(ptr_b_ff);
                  state_in = S_DONE;
               end else begin
                  state_in = S_DROP;
               end
            end else if (ptr_a_ff < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_a_ff[AW-1:0];
               ptr_b_in  = ptr_a_ff;
               ptr_a_in  = ptr_a_ff + CW'(1);
               flag_in   = 1'b1;
            end else begin
               flag_in = 1'b0;
               if (!flag_ff) begin
                  status_in = STS_NOTFOUND;
                  state_in  = S_DONE;
               end
            end
         end

         // Choose how to close the gap at ptr_b
         S_DROP: begin
            if (removal_mode) begin
               mem_re    = 1'b1;
               mem_raddr = last[AW-1:0];
               state_in  = S_MOVE;
            end else begin
               ptr_a_in = ptr_b_ff + CW'(1);
               flag_in  = 1'b0;
               state_in = S_SHIFT;
            end
         end

         // Move the last entry into the gap
         S_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_b_ff[AW-1:0];
            mem_wdata = mem_rdata;
            count_in  = last;
            state_in  = S_DONE;
         end

         // Shift later entries down, one read and one write per cycle
         S_SHIFT: begin
            if (flag_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_b_ff[AW-1:0];
               mem_wdata = mem_rdata;
               ptr_b_in  = ptr_b_ff + CW'(1);
            end
            if (ptr_a_ff < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_a_ff[AW-1:0];
               ptr_a_in  = ptr_a_ff + CW'(1);
               flag_in   = 1'b1;
            end else begin
               flag_in = 1'b0;
               if (!flag_ff) begin
                  count_in = last;
                  state_in = S_DONE;
               end
            end
         end

         // Read the high word, hold the low one
         S_REV_RDH: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_b_ff[AW-1:0];
            hold_in   = mem_rdata;
            state_in  = S_REV_WRL;
         end

         // Write the low slot, fetch the next low word
         S_REV_WRL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_a_ff[AW-1:0];
            mem_wdata = mem_rdata;
            if (rev_more) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_a_ff[AW-1:0] + AW'(1);
            end
            state_in = S_REV_WRH;
         end

         // Write the high slot, fetch the next high word
         S_REV_WRH: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_b_ff[AW-1:0];
            mem_wdata = hold_ff;
            if (rev_more) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_b_ff[AW-1:0] - AW'(1);
               hold_in   = mem_rdata;
               ptr_a_in  = ptr_a_ff + CW'(1);
               ptr_b_in  = ptr_b_ff - CW'(1);
               state_in  = S_REV_WRL;
            end else begin
               state_in = S_DONE;
            end
         end

         // Offer the result until taken
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle                 = (state_ff == S_IDLE);
   assign res_data.status      = status_ff;
   assign res_data.read_value  = rd_ext[31:0];
   assign res_data.found_index = fi_ff;
   assign res_data.fill_count  = 9'(count_ff);

   `BATE_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY), "fill count above capacity")
   `BATE_ASSERT_SAME(a_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write same slot")
   `BATE_ASSERT_SAME(a_idle_quiet, state_ff == S_IDLE || state_ff == S_DONE, !mem_we && !mem_re, "memory access while not working")
   `BATE_ASSERT_NEXT(a_count_hold, state_ff == S_IDLE || state_ff == S_DONE, $stable(count_ff), "fill count moved while not working")
   `BATE_ASSERT_NEXT(a_result_hold, res_valid && !res_take, res_valid && $stable(status_ff), "pending result dropped or changed")

endmodule

// ===== dv/array_table_tracker_pkg.sv =====
`timescale 1ns / 1ps

package array_table_tracker_pkg;
   import bate_pkg::*;

   localparam int unsigned TABLE_SLOTS = 256;
   localparam int unsigned REPORT_LIMIT = 10;

   // Mirror of the array state; predicts one reply per request transfer
   class array_table_tracker;
      logic [31:0]  cells [TABLE_SLOTS];
      int unsigned  fill;
      bit           move_last;
      bate_rsp_type expected_replies [$];
      int unsigned  errors;

      function new();
         foreach (cells[i]) cells[i] = '0;
         fill = 0;
         move_last = 1'b0;
         errors = 0;
      endfunction

      function void set_move_last(bit mode);
         move_last = mode;
      endfunction

      function int unsigned pending_count();
         return expected_replies.size();
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
      endfunction

      // Close the gap left at pos, by shifting or by moving the last entry in
      function void drop_entry(int unsigned pos);
         if (!move_last) begin
            for (int unsigned i = pos; i + 1 < fill; i++) cells[i] = cells[i + 1];
         end else begin
            cells[pos] = cells[fill - 1];
         end
         fill--;
      endfunction

      function bit find_first(logic [31:0] v, output int unsigned pos);
         pos = 0;
         for (int unsigned i = 0; i < fill; i++) begin
            if (cells[i] == v) begin
               pos = i;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Apply one accepted request to the mirror and queue its reply
      function void note_request(bate_req_type r);
         bate_rsp_type want;
         int unsigned  pos;
         int unsigned  lo;
         int unsigned  hi;
         logic [31:0]  tmp;
         want = '0;
         want.status = STS_OK;
         case (r.action)
            ACT_PUSH: begin
               if (r.value == '0) want.status = STS_NULL;
               else if (fill >= TABLE_SLOTS) want.status = STS_FULL;
               else begin
                  cells[fill] = r.value;
                  fill++;
               end
            end
            ACT_POP: begin
               if (fill == 0) want.status = STS_UNDER;
               else begin
                  fill--;
                  want.read_value = cells[fill];
               end
            end
            ACT_GET: begin
               if (r.index < fill) want.read_value = cells[r.index];
               else want.status = STS_RANGE;
            end
            ACT_SET: begin
               if (r.value == '0) want.status = STS_NULL;
               else if (r.index < fill) cells[r.index] = r.value;
               else want.status = STS_RANGE;
            end
            ACT_REM_VAL: begin
               if (r.value == '0) want.status = STS_NULL;
               else if (find_first(r.value, pos)) drop_entry(pos);
               else want.status = STS_NOTFOUND;
            end
            ACT_REM_IDX: begin
               if (r.index < fill) drop_entry(r.index);
               else want.status = STS_RANGE;
            end
            ACT_FIND: begin
               // zero is an ordinary word here
               if (find_first(r.value, pos)) want.found_index = pos[7:0];
               else want.status = STS_NOTFOUND;
            end
            ACT_CLEAR: fill = 0;
            ACT_REVERSE: begin
               if (fill > 1) begin
                  lo = 0;
                  hi = fill - 1;
                  while (lo < hi) begin
                     tmp = cells[lo];
                     cells[lo] = cells[hi];
                     cells[hi] = tmp;
                     lo++;
                     hi--;
                  end
               end
            end
            default: ;  // unused codes leave the array alone
         endcase
         want.fill_count = fill[8:0];
         expected_replies.push_back(want);
      endfunction

      // Compare a reply transfer against the oldest prediction
      function void check_reply(bate_rsp_type got);
         bate_rsp_type want;
         if (expected_replies.size() == 0) begin
            note_error($sformatf("unexpected reply: status=%0d rd=%h idx=%0d cnt=%0d",
                                 got.status, got.read_value, got.found_index,
                                 got.fill_count));
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status || got.read_value !== want.read_value ||
             got.found_index !== want.found_index || got.fill_count !== want.fill_count)
            note_error($sformatf({"reply mismatch: want status=%0d rd=%h idx=%0d cnt=%0d,",
                                  " got status=%0d rd=%h idx=%0d cnt=%0d"},
                                 want.status, want.read_value, want.found_index,
                                 want.fill_count, got.status, got.read_value,
                                 got.found_index, got.fill_count));
      endfunction

      // Count any prediction still waiting, then hand back the error total
      function int unsigned close_out();
         if (expected_replies.size() != 0)
            note_error($sformatf("%0d replies never arrived", expected_replies.size()));
         return errors;
      endfunction
   endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import bate_pkg::*;
   import array_table_tracker_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned TAIL_CYCLES = 40;
   localparam logic [3:0]  UNKNOWN_ACTION = 4'hF;

   typedef enum int unsigned {PACE_FREE, PACE_COIN, PACE_HEAVY, PACE_BEAT} pace_kind_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   bate_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   bate_rsp_type rsp_data;
   logic         csr_wr_en;
   logic         csr_wr_data;

   array_table_tracker tracker;
   logic [31:0]        value_pool [8];
   int unsigned        burst_left;
   bit                 hold_off_request = 1'b0;

   bounded_array_table_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // End the run if it hangs
   initial begin : watchdog
      int unsigned n;
      n = 0;
      while (n < CYCLE_LIMIT) begin
         @(posedge clock);
         n++;
      end
      $display("FAIL bounded_array_table_engine");
      $finish;
   end

   // Receiver pacing: runs of free flow, coin flips, heavy stalling and a beat,
   // plus one long hold-off on request
   initial begin : rsp_pacer
      int unsigned   hold_left;
      int unsigned   run_left;
      pace_kind_type style;
      hold_left = 0;
      run_left = 0;
      style = PACE_FREE;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (run_left == 0) begin
               style = pace_kind_type'($urandom_range(0, 3));
               run_left = $urandom_range(8, 60);
            end
            run_left--;
            case (style)
               PACE_FREE:  rsp_stall <= 1'b0;
               PACE_COIN:  rsp_stall <= ($urandom_range(0, 1) == 1);
               PACE_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:    rsp_stall <= ((run_left % 5) < 2);
            endcase
         end
      end
   end

   // Check every reply transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_reply(rsp_data);
   end

   function automatic bate_req_type op(logic [3:0] action, logic [7:0] index,
                                       logic [31:0] value);
      bate_req_type r;
      r.action = action;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   // Random request: index mostly below the fill, values mostly from a small pool
   function automatic bate_req_type make_item(int unsigned push_weight);
      bate_req_type r;
      int unsigned  roll;
      if ($urandom_range(0, 3) != 0 && tracker.fill != 0)
         r.index = 8'($urandom_range(0, tracker.fill - 1));
      else
         r.index = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 10) r.value = '0;
      else if (roll < 65) r.value = value_pool[$urandom_range(0, 7)];
      else r.value = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < push_weight) r.action = ACT_PUSH;
      else begin
         roll = $urandom_range(0, 99);
         if (roll < 14) r.action = ACT_POP;
         else if (roll < 30) r.action = ACT_GET;
         else if (roll < 44) r.action = ACT_SET;
         else if (roll < 58) r.action = ACT_REM_VAL;
         else if (roll < 70) r.action = ACT_REM_IDX;
         else if (roll < 84) r.action = ACT_FIND;
         else if (roll < 87) r.action = ACT_CLEAR;
         else if (roll < 95) r.action = ACT_REVERSE;
         else r.action = 4'($urandom_range(9, 15));
      end
      return r;
   endfunction

   // Drop valid and wait out a gap set by n
   task automatic pause_sender(input int unsigned n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Present one request and hold it until the transfer
   task automatic send_item(input bate_req_type r);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      tracker.note_request(r);
   endtask

   // Send in bursts of random length with random gaps between them
   task automatic offer(input bate_req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         pause_sender($urandom_range(1, 12));
      end
      send_item(r);
      burst_left--;
   endtask

   // Hold the sender until every reply is back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_count() != 0) @(posedge clock);
   endtask

   task automatic set_removal_mode(input logic move_last);
      settle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= move_last;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_move_last(move_last);
      burst_left = 0;
   endtask

   initial begin : stimulus
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      burst_left = 0;
      value_pool[0] = 32'hFFFF_FFFF;
      value_pool[1] = 32'h0000_0001;
      value_pool[2] = 32'h8000_0000;
      value_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom_range(1, 32'hFFFF_FFFF);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty array, null arguments, extremes, shifting removal
      offer(op(ACT_POP, 8'd0, 32'd0));
      offer(op(ACT_GET, 8'd0, 32'd0));
      offer(op(ACT_REVERSE, 8'd0, 32'd0));
      offer(op(ACT_PUSH, 8'd0, 32'd0));
      offer(op(ACT_PUSH, 8'd0, 32'hFFFF_FFFF));
      offer(op(ACT_PUSH, 8'd0, 32'h0000_0001));
      offer(op(ACT_PUSH, 8'd0, 32'h8000_0000));
      offer(op(ACT_PUSH, 8'd0, 32'h0000_0001));
      offer(op(ACT_FIND, 8'd0, 32'd0));
      offer(op(ACT_FIND, 8'd0, 32'h0000_0001));
      offer(op(ACT_SET, 8'd0, 32'd0));
      offer(op(ACT_SET, 8'd2, 32'h5A5A_A5A5));
      offer(op(ACT_SET, 8'd255, 32'h0000_0005));
      offer(op(ACT_REM_VAL, 8'd0, 32'd0));
      offer(op(ACT_REM_VAL, 8'd0, 32'h0000_0001));
      offer(op(ACT_REM_VAL, 8'd0, 32'h0000_0007));
      offer(op(ACT_REM_IDX, 8'd200, 32'd0));
      offer(op(ACT_REVERSE, 8'd0, 32'd0));
      offer(op(ACT_GET, 8'd2, 32'd0));
      offer(op(UNKNOWN_ACTION, 8'hFF, 32'hFFFF_FFFF));
      offer(op(ACT_POP, 8'd0, 32'd0));
      offer(op(ACT_CLEAR, 8'd0, 32'd0));

      // Directed: removal by moving the last entry into the gap
      set_removal_mode(1'b1);
      offer(op(ACT_PUSH, 8'd0, 32'h0000_0011));
      offer(op(ACT_PUSH, 8'd0, 32'h0000_0022));
      offer(op(ACT_PUSH, 8'd0, 32'h0000_0033));
      offer(op(ACT_PUSH, 8'd0, 32'h0000_0044));
      offer(op(ACT_REM_VAL, 8'd0, 32'h0000_0022));
      offer(op(ACT_REM_IDX, 8'd0, 32'd0));
      offer(op(ACT_GET, 8'd1, 32'd0));

      // Fill to capacity, then push against a full array
      while (tracker.fill < TABLE_SLOTS) offer(make_item(96));
      repeat (4) offer(make_item(100));
      offer(op(ACT_REVERSE, 8'd0, 32'd0));

      // Long receiver hold-off with the sender still offering back to back
      hold_off_request = 1'b1;
      burst_left = 14;
      repeat (12) offer(make_item(50));

      // Shifting removal on a well-stocked array, draining down
      set_removal_mode(1'b0);
      repeat (70) offer(make_item(20));

      set_removal_mode(1'b1);
      repeat (40) offer(make_item(40));

      set_removal_mode(1'b0);
      repeat (30) offer(make_item(35));

      // Drain and let the block settle
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.close_out() == 0) $display("PASS bounded_array_table_engine");
      else $display("FAIL bounded_array_table_engine");
      $finish;
   end

endmodule

// ===== bounded_array_table_engine.f =====
+incdir+hw/rtl
hw/rtl/bate_pkg.sv
hw/rtl/bate_ram.sv
hw/rtl/bate_ctrl.sv
hw/rtl/bounded_array_table_engine.sv
dv/array_table_tracker_pkg.sv
dv/tb_top.sv
